// ===== hw/rtl/cpc_pkg.sv =====
package cpc_pkg;

   localparam int COORD_WIDTH = 16;
   localparam int EDGE_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * EDGE_WIDTH;
   localparam int DIFF_WIDTH  = PROD_WIDTH + 1;

   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic CSR_IDX_ORIENTATION_MODE = 1'b0;

   localparam logic [1:0] SIGN_NONE = 2'd0;
   localparam logic [1:0] SIGN_POS  = 2'd1;
   localparam logic [1:0] SIGN_NEG  = 2'd2;

   localparam logic [1:0] STATUS_CONVEX     = 2'd0;
   localparam logic [1:0] STATUS_NOT_CONVEX = 2'd1;
   localparam logic [1:0] STATUS_TOO_FEW    = 2'd2;

   localparam logic MODE_CLOCKWISE = 1'b0;

   typedef struct packed {
      logic signed [EDGE_WIDTH-1:0] x;
      logic signed [EDGE_WIDTH-1:0] y;
   } vec_type;

   typedef struct packed {
      logic last;
      logic few;
      logic chk_enter;
      logic chk_close;
   } ctl_type;

   typedef struct packed {
      ctl_type ctl;
      vec_type prior_edge;
      vec_type edge_in;
      vec_type closing;
      vec_type first_edge;
   } edges_type;

   typedef struct packed {
      ctl_type ctl;
      logic signed [PROD_WIDTH-1:0] p1a;
      logic signed [PROD_WIDTH-1:0] p1b;
      logic signed [PROD_WIDTH-1:0] p2a;
      logic signed [PROD_WIDTH-1:0] p2b;
      logic signed [PROD_WIDTH-1:0] p3a;
      logic signed [PROD_WIDTH-1:0] p3b;
   } prods_type;

   typedef struct packed {
      logic [1:0] turn_sign;
      logic       failed;
   } fold_type;

   function automatic fold_type fold_turn(fold_type st, logic [1:0] s, logic mode);
      fold_type r;
      r = st;
      if (s == SIGN_NONE) begin
         r.failed = 1'b1;
      end else if (mode == MODE_CLOCKWISE) begin
         if (s != SIGN_NEG) r.failed = 1'b1;
      end else if (st.turn_sign == SIGN_NONE) begin
         r.turn_sign = s;
      end else if (st.turn_sign != s) begin
         r.failed = 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/cpc_csr.sv =====
module cpc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cpc_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  logic [cpc_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic [cpc_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                pready,
   output logic                                orientation_mode
);

   logic mode_ff;
   logic mode_in;
   logic hit;

   assign hit = paddr[cpc_pkg::CSR_ADDR_WIDTH-1] == cpc_pkg::CSR_IDX_ORIENTATION_MODE;

   always_comb begin
      mode_in = mode_ff;
      if (psel && penable && pwrite && hit) mode_in = pwdata[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign pready           = 1'b1;
   assign prdata           = hit ? {{(cpc_pkg::CSR_DATA_WIDTH-1){1'b0}}, mode_ff}
                                 : '0;
   assign orientation_mode = mode_ff;

endmodule

// ===== hw/rtl/cpc_front.sv =====
module cpc_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [cpc_pkg::COORD_WIDTH-1:0] req_vertex_x,
   input  logic signed [cpc_pkg::COORD_WIDTH-1:0] req_vertex_y,
   input  logic                                   req_last_vertex,
   input  logic                                   s1_take,
   output logic                                   s1_valid,
   output cpc_pkg::edges_type                     s1_data
);

   localparam int CW = cpc_pkg::COORD_WIDTH;

   logic signed [CW-1:0] first_x_ff, first_y_ff, prior_x_ff, prior_y_ff;
   logic signed [CW-1:0] first_x_in, first_y_in, prior_x_in, prior_y_in;
   cpc_pkg::vec_type     first_edge_ff, first_edge_in, prior_edge_ff, prior_edge_in;
   logic [1:0]           seen_count_ff, seen_count_in;
   logic                 valid_ff, valid_in;
   cpc_pkg::edges_type   data_ff, data_in;
   cpc_pkg::vec_type     e, c;
   logic                 load, accept;

   assign load      = !valid_ff || s1_take;
   assign req_stall = !load;
   assign accept    = req_valid && load;

   assign e.x = {req_vertex_x[CW-1], req_vertex_x} - {prior_x_ff[CW-1], prior_x_ff};
   assign e.y = {req_vertex_y[CW-1], req_vertex_y} - {prior_y_ff[CW-1], prior_y_ff};
   assign c.x = {first_x_ff[CW-1], first_x_ff} - {req_vertex_x[CW-1], req_vertex_x};
   assign c.y = {first_y_ff[CW-1], first_y_ff} - {req_vertex_y[CW-1], req_vertex_y};

   always_comb begin
      first_x_in    = first_x_ff;
      first_y_in    = first_y_ff;
      prior_x_in    = prior_x_ff;
      prior_y_in    = prior_y_ff;
      first_edge_in = first_edge_ff;
      prior_edge_in = prior_edge_ff;
      seen_count_in = seen_count_ff;
      valid_in      = valid_ff;
      data_in       = data_ff;
      if (load) begin
         valid_in                   = accept;
         data_in.ctl.last           = req_last_vertex;
         data_in.ctl.few            = req_last_vertex && !seen_count_ff[1];
         data_in.ctl.chk_enter      = seen_count_ff[1];
         data_in.ctl.chk_close      = req_last_vertex && seen_count_ff[1];
         data_in.prior_edge         = prior_edge_ff;
         data_in.edge_in            = e;
         data_in.closing            = c;
         data_in.first_edge         = first_edge_ff;
      end
      if (accept) begin
         if (seen_count_ff == 2'd0) begin
            first_x_in = req_vertex_x;
            first_y_in = req_vertex_y;
         end else begin
            if (seen_count_ff == 2'd1) first_edge_in = e;
            prior_edge_in = e;
         end
         prior_x_in = req_vertex_x;
         prior_y_in = req_vertex_y;
         // saturate at three; a last vertex starts a new polygon
         if (req_last_vertex) begin
            seen_count_in = 2'd0;
         end else if (seen_count_ff != 2'd3) begin
            seen_count_in = seen_count_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_count_ff <= 2'd0;
         valid_ff      <= 1'b0;
      end else begin
         seen_count_ff <= seen_count_in;
         valid_ff      <= valid_in;
      end
      first_x_ff    <= first_x_in;
      first_y_ff    <= first_y_in;
      prior_x_ff    <= prior_x_in;
      prior_y_ff    <= prior_y_in;
      first_edge_ff <= first_edge_in;
      prior_edge_ff <= prior_edge_in;
      data_ff       <= data_in;
   end

   assign s1_valid = valid_ff;
   assign s1_data  = data_ff;

endmodule

// ===== hw/rtl/cpc_cross.sv =====
module cpc_cross (
   input  logic               clock,
   input  logic               reset,
   input  logic               s1_valid,
   input  cpc_pkg::edges_type s1_data,
   output logic               s1_take,
   input  logic               s2_take,
   output logic               s2_valid,
   output cpc_pkg::prods_type s2_data
);

   localparam int PW = cpc_pkg::PROD_WIDTH;

   logic               valid_ff, valid_in;
   cpc_pkg::prods_type data_ff, data_in;
   logic               load;

   assign load    = !valid_ff || s2_take;
   assign s1_take = load;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in     = s1_valid;
         data_in.ctl  = s1_data.ctl;
         // turn at the entering vertex, at the last vertex, at the first vertex
         data_in.p1a  = PW'(s1_data.prior_edge.x) * PW'(s1_data.edge_in.y);
         data_in.p1b  = PW'(s1_data.prior_edge.y) * PW'(s1_data.edge_in.x);
         data_in.p2a  = PW'(s1_data.edge_in.x) * PW'(s1_data.closing.y);
         data_in.p2b  = PW'(s1_data.edge_in.y) * PW'(s1_data.closing.x);
         data_in.p3a  = PW'(s1_data.closing.x) * PW'(s1_data.first_edge.y);
         data_in.p3b  = PW'(s1_data.closing.y) * PW'(s1_data.first_edge.x);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign s2_valid = valid_ff;
   assign s2_data  = data_ff;

endmodule

// ===== hw/rtl/cpc_judge.sv =====
module cpc_judge (
   input  logic               clock,
   input  logic               reset,
   input  logic               orientation_mode,
   input  logic               s2_valid,
   input  cpc_pkg::prods_type s2_data,
   output logic               s2_take,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status
);

   localparam int PW = cpc_pkg::PROD_WIDTH;
   localparam int DW = cpc_pkg::DIFF_WIDTH;

   cpc_pkg::fold_type    st_ff, st_in, st1, st2, st3;
   logic                 out_valid_ff, out_valid_in;
   logic [1:0]           status_ff, status_in;
   logic signed [DW-1:0] d1, d2, d3;
   logic [1:0]           sg1, sg2, sg3;
   logic                 out_free, consume;

   function automatic logic [1:0] sign_of(logic signed [DW-1:0] d);
      logic [1:0] s;
      if (d == '0) begin
         s = cpc_pkg::SIGN_NONE;
      end else if (d[DW-1]) begin
         s = cpc_pkg::SIGN_NEG;
      end else begin
         s = cpc_pkg::SIGN_POS;
      end
      return s;
   endfunction

   assign out_free = !out_valid_ff || !rsp_stall;
   assign s2_take  = !s2_data.ctl.last || out_free;
   assign consume  = s2_valid && s2_take;

   assign d1  = {s2_data.p1a[PW-1], s2_data.p1a} - {s2_data.p1b[PW-1], s2_data.p1b};
   assign d2  = {s2_data.p2a[PW-1], s2_data.p2a} - {s2_data.p2b[PW-1], s2_data.p2b};
   assign d3  = {s2_data.p3a[PW-1], s2_data.p3a} - {s2_data.p3b[PW-1], s2_data.p3b};
   assign sg1 = sign_of(d1);
   assign sg2 = sign_of(d2);
   assign sg3 = sign_of(d3);

   always_comb begin
      st1 = s2_data.ctl.chk_enter ? cpc_pkg::fold_turn(st_ff, sg1, orientation_mode) : st_ff;
      st2 = cpc_pkg::fold_turn(st1, sg2, orientation_mode);
      st3 = s2_data.ctl.chk_close ? cpc_pkg::fold_turn(st2, sg3, orientation_mode) : st1;

      st_in        = st_ff;
      out_valid_in = out_valid_ff;
      status_in    = status_ff;
      if (out_valid_ff && !rsp_stall) out_valid_in = 1'b0;
      if (consume) begin
         if (s2_data.ctl.last) begin
            st_in        = '0;
            out_valid_in = 1'b1;
            if (s2_data.ctl.few) begin
               status_in = cpc_pkg::STATUS_TOO_FEW;
            end else if (st3.failed) begin
               status_in = cpc_pkg::STATUS_NOT_CONVEX;
            end else begin
               status_in = cpc_pkg::STATUS_CONVEX;
            end
         end else begin
            st_in = st3;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         out_valid_ff <= out_valid_in;
      end
      status_ff <= status_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_status = status_ff;

endmodule

// ===== hw/rtl/convex_polygon_check_unit.sv =====
// Channel  Direction  Ports                                        Moves
// req      in         req_valid/req_stall, req_vertex_x/y, last     one vertex per item
// rsp      out        rsp_valid/rsp_stall, rsp_status               one status per polygon
// csr      in/out     psel, penable, pwrite, paddr, pwdata, prdata  orientation_mode at 0x0
//
// One vertex item is taken per cycle while req_stall is low; a last vertex passes the edge
// register, the cross-product multiplier register and the sign fold into the result register.
// Reset clears the vertex count, turn sign, failure flag, valid bits and the mode register.
// A held status stalls only a last-vertex item; other items flow on until queued behind one.
module convex_polygon_check_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [cpc_pkg::COORD_WIDTH-1:0] req_vertex_x,
   input  logic signed [cpc_pkg::COORD_WIDTH-1:0] req_vertex_y,
   input  logic                                   req_last_vertex,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [1:0]                             rsp_status,
   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [cpc_pkg::CSR_ADDR_WIDTH-1:0]     paddr,
   input  logic [cpc_pkg::CSR_DATA_WIDTH-1:0]     pwdata,
   output logic [cpc_pkg::CSR_DATA_WIDTH-1:0]     prdata,
   output logic                                   pready
);

   logic               orientation_mode;
   logic               s1_valid, s1_take, s2_valid, s2_take;
   cpc_pkg::edges_type s1_data;
   cpc_pkg::prods_type s2_data;

   cpc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .orientation_mode (orientation_mode)
   );

   cpc_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_vertex_x    (req_vertex_x),
      .req_vertex_y    (req_vertex_y),
      .req_last_vertex (req_last_vertex),
      .s1_take         (s1_take),
      .s1_valid        (s1_valid),
      .s1_data         (s1_data)
   );

   cpc_cross u_cross (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1_data  (s1_data),
      .s1_take  (s1_take),
      .s2_take  (s2_take),
      .s2_valid (s2_valid),
      .s2_data  (s2_data)
   );

   cpc_judge u_judge (
      .clock            (clock),
      .reset            (reset),
      .orientation_mode (orientation_mode),
      .s2_valid         (s2_valid),
      .s2_data          (s2_data),
      .s2_take          (s2_take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status)
   );

endmodule

// ===== dv/convex_polygon_check_unit_test.sv =====
module convex_polygon_check_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW = cpc_pkg::COORD_WIDTH;
   localparam int EW = cpc_pkg::EDGE_WIDTH;
   localparam int AW = cpc_pkg::CSR_ADDR_WIDTH;
   localparam int DW = cpc_pkg::CSR_DATA_WIDTH;

   localparam logic MODE_EITHER = 1'b1;
   localparam logic [AW-1:0] MODE_ADDR = AW'(4 * cpc_pkg::CSR_IDX_ORIENTATION_MODE);
   localparam logic [AW-1:0] SPARE_ADDR = AW'(4);
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 500;
   localparam int PRINT_CAP = 20;

   class convexity_scoreboard;
      logic mode;
      logic signed [CW-1:0] first_x, first_y, prior_x, prior_y;
      logic signed [EW-1:0] first_ex, first_ey, prior_ex, prior_ey;
      logic [1:0] seen;
      logic [1:0] turn;
      logic failed;
      logic [1:0] status_due[$];
      int errors;

      function new();
         mode = cpc_pkg::MODE_CLOCKWISE;
         errors = 0;
         clear();
      endfunction

      function void clear();
         first_x = '0;
         first_y = '0;
         prior_x = '0;
         prior_y = '0;
         first_ex = '0;
         first_ey = '0;
         prior_ex = '0;
         prior_ey = '0;
         seen = '0;
         turn = cpc_pkg::SIGN_NONE;
         failed = 1'b0;
      endfunction

      function void judge_turn(logic signed [EW-1:0] ax, logic signed [EW-1:0] ay,
                               logic signed [EW-1:0] bx, logic signed [EW-1:0] by);
         longint c;
         logic [1:0] s;
         c = longint'(ax) * longint'(by) - longint'(ay) * longint'(bx);
         s = (c > 0) ? cpc_pkg::SIGN_POS : ((c < 0) ? cpc_pkg::SIGN_NEG : cpc_pkg::SIGN_NONE);
         if (s == cpc_pkg::SIGN_NONE) begin
            failed = 1'b1;
         end else if (mode == cpc_pkg::MODE_CLOCKWISE) begin
            if (s != cpc_pkg::SIGN_NEG) failed = 1'b1;
         end else if (turn == cpc_pkg::SIGN_NONE) begin
            turn = s;
         end else if (turn != s) begin
            failed = 1'b1;
         end
      endfunction

      function void note_vertex(logic signed [CW-1:0] x, logic signed [CW-1:0] y,
                                logic last);
         logic signed [EW-1:0] ex, ey, cx, cy;
         if (seen == 2'd0) begin
            first_x = x;
            first_y = y;
         end else begin
            ex = x - prior_x;
            ey = y - prior_y;
            if (seen == 2'd1) begin
               first_ex = ex;
               first_ey = ey;
            end else begin
               judge_turn(prior_ex, prior_ey, ex, ey);
            end
            prior_ex = ex;
            prior_ey = ey;
         end
         prior_x = x;
         prior_y = y;
         if (seen < 2'd3) seen = seen + 2'd1;
         if (!last) return;
         if (seen < 2'd3) begin
            status_due.push_back(cpc_pkg::STATUS_TOO_FEW);
         end else begin
            // close the polygon: turn at the last vertex, then at the first
            cx = first_x - x;
            cy = first_y - y;
            judge_turn(prior_ex, prior_ey, cx, cy);
            judge_turn(cx, cy, first_ex, first_ey);
            status_due.push_back(failed ? cpc_pkg::STATUS_NOT_CONVEX : cpc_pkg::STATUS_CONVEX);
         end
         clear();
      endfunction

      function int pending();
         return status_due.size();
      endfunction

      task report(string msg);
         if (errors < PRINT_CAP) $display("ERROR: %s", msg);
         errors++;
      endtask

      task check_status(logic [1:0] got);
         logic [1:0] want;
         if (status_due.size() == 0) begin
            report($sformatf("status %0d with no polygon closed", got));
         end else begin
            want = status_due.pop_front();
            if (got !== want) report($sformatf("status %0d, expected %0d", got, want));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [CW-1:0] req_vertex_x = '0;
   logic signed [CW-1:0] req_vertex_y = '0;
   logic req_last_vertex = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_status;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [AW-1:0] paddr = '0;
   logic [DW-1:0] pwdata = '0;
   logic [DW-1:0] prdata;
   logic pready;

   convexity_scoreboard sb;
   bit gaps_on = 1'b1;
   bit stalls_on = 1'b1;
   int sent = 0;
   int cycles = 0;
   int poly_x[$];
   int poly_y[$];
   int ctr_x, ctr_y;

   convex_polygon_check_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_vertex_x(req_vertex_x),
      .req_vertex_y(req_vertex_y),
      .req_last_vertex(req_last_vertex),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_status(rsp_status);
   end

   // receiver back-pressure in random bursts
   initial begin
      forever begin
         @(posedge clock);
         if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 10)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_vertex(int x, int y, bit last);
      if (gaps_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_vertex_x <= CW'(x);
      req_vertex_y <= CW'(y);
      req_last_vertex <= last;
      do @(posedge clock); while (req_stall);
      sb.note_vertex(req_vertex_x, req_vertex_y, req_last_vertex);
      sent++;
   endtask

   task automatic send_polygon(bit close);
      foreach (poly_x[i]) send_vertex(poly_x[i], poly_y[i], close && (i == poly_x.size() - 1));
      poly_x.delete();
      poly_y.delete();
   endtask

   function automatic void add_pt(int x, int y);
      poly_x.push_back(x);
      poly_y.push_back(y);
   endfunction

   function automatic int fit(int v);
      return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
   endfunction

   // points near a circle; clockwise order walks the angles backward
   task automatic build_convex(int n, bit cw, int r);
      real step, base, ang;
      int k;
      ctr_x = int'($urandom_range(0, 2 * (32767 - r))) - (32767 - r);
      ctr_y = int'($urandom_range(0, 2 * (32767 - r))) - (32767 - r);
      step = 6.283185307 / n;
      base = step * $urandom_range(0, 999) / 1000.0;
      for (int i = 0; i < n; i++) begin
         k = cw ? n - 1 - i : i;
         ang = base + step * k + step * 0.4 * ($urandom_range(0, 1000) / 1000.0 - 0.5);
         add_pt(fit(ctr_x + $rtoi(r * $cos(ang))), fit(ctr_y + $rtoi(r * $sin(ang))));
      end
   endtask

   task automatic random_polygon();
      int pick, n, r, k;
      pick = $urandom_range(0, 19);
      n = $urandom_range(3, 8);
      if (pick == 0) r = 32767;
      else if (pick < 3) r = $urandom_range(2, 20);
      else r = $urandom_range(64, 16000);
      if (pick < 12) begin
         build_convex(n, $urandom_range(0, 1), r);
         send_polygon(1'b1);
      end else if (pick < 15) begin
         // pull one vertex toward the center to dent the outline
         build_convex(n + 1, $urandom_range(0, 1), r);
         k = $urandom_range(0, n);
         poly_x[k] = ctr_x + (poly_x[k] - ctr_x) / 4;
         poly_y[k] = ctr_y + (poly_y[k] - ctr_y) / 4;
         send_polygon(1'b1);
      end else if (pick == 15) begin
         build_convex($urandom_range(9, 40), $urandom_range(0, 1), $urandom_range(2000, 16000));
         send_polygon($urandom_range(0, 3) != 0);
      end else if (pick < 18) begin
         repeat ($urandom_range(1, 8)) add_pt(int'($urandom_range(0, 65535)) - 32768,
                                             int'($urandom_range(0, 65535)) - 32768);
         send_polygon(1'b1);
      end else begin
         repeat ($urandom_range(1, 2)) add_pt(int'($urandom_range(0, 65535)) - 32768,
                                             int'($urandom_range(0, 65535)) - 32768);
         send_polygon(1'b1);
      end
   endtask

   // let in-flight statuses arrive, then the pipeline empty out
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [AW-1:0] addr, logic [DW-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == MODE_ADDR) sb.mode = data[0];
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_mode_readback();
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= MODE_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== DW'(sb.mode))
         sb.report($sformatf("mode reads %0h, expected %0h", prdata, sb.mode));
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic mode;
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      check_mode_readback();
      csr_write(MODE_ADDR, DW'(cpc_pkg::MODE_CLOCKWISE));
      // only offset zero holds a register
      csr_write(SPARE_ADDR, '1);
      check_mode_readback();

      // too few vertices
      add_pt(32767, -32768);
      add_pt(0, 0);
      send_polygon(1'b1);
      // clockwise triangle spanning the full range, then the same one reversed
      add_pt(-32768, -32768);
      add_pt(-32768, 32767);
      add_pt(32767, 32767);
      send_polygon(1'b1);
      add_pt(-32768, -32768);
      add_pt(32767, 32767);
      add_pt(-32768, 32767);
      send_polygon(1'b1);
      // collinear point on a clockwise square
      add_pt(0, 0);
      add_pt(0, 100);
      add_pt(0, 200);
      add_pt(200, 200);
      add_pt(200, 0);
      send_polygon(1'b1);
      // repeated vertex
      add_pt(0, 0);
      add_pt(0, 100);
      add_pt(0, 100);
      add_pt(100, 0);
      send_polygon(1'b1);

      settle();
      csr_write(MODE_ADDR, '1);
      check_mode_readback();
      add_pt(0, 0);
      add_pt(100, 0);
      add_pt(0, 100);
      send_polygon(1'b1);
      add_pt(0, 0);
      add_pt(0, 100);
      add_pt(100, 0);
      send_polygon(1'b1);
      // dent flips the turn sign
      add_pt(0, 0);
      add_pt(100, 0);
      add_pt(20, 20);
      add_pt(0, 100);
      send_polygon(1'b1);
      // switch to clockwise-only partway through a counterclockwise square
      add_pt(0, 0);
      add_pt(100, 0);
      add_pt(100, 100);
      send_polygon(1'b0);
      settle();
      csr_write(MODE_ADDR, DW'(cpc_pkg::MODE_CLOCKWISE));
      send_vertex(0, 100, 1'b1);

      for (int phase = 0; phase < 4; phase++) begin
         settle();
         if (phase == 0) mode = MODE_EITHER;
         else if (phase == 1) mode = cpc_pkg::MODE_CLOCKWISE;
         else mode = $urandom_range(0, 1);
         // quiet handshakes in the closing phase
         gaps_on = (phase < 3);
         stalls_on = (phase < 3);
         csr_write(MODE_ADDR, {31'($urandom_range(0, 32'h7fff_ffff)), mode});
         check_mode_readback();
         begin
            int stop_at;
            stop_at = sent + PHASE_ITEMS;
            while (sent < stop_at) random_polygon();
         end
      end

      // a trailing unclosed polygon would never report; close it
      send_vertex(0, 0, 1'b1);
      settle();
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/cpc_pkg.sv
hw/rtl/cpc_csr.sv
hw/rtl/cpc_front.sv
hw/rtl/cpc_cross.sv
hw/rtl/cpc_judge.sv
hw/rtl/convex_polygon_check_unit.sv
dv/convex_polygon_check_unit_test.sv
